FILE: design/pstp_pkg.sv
// shared types and constants for the periodic slot timer pool
`timescale 1ns / 1ps

package pstp_pkg;

    localparam int POOL_SIZE = 8;
    localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

    localparam logic [31:0] STAMP_SENTINEL = 32'hFFFF_FFFF;

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_OPEN  = 3'd1;
    localparam logic [2:0] MODE_CHECK = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_CLEAR = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_CHECK
    } t_state;

    typedef struct packed {
        logic [15:0] period;
        logic [31:0] last_time;
    } t_slot;

endpackage

FILE: design/pstp_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module pstp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/periodic_slot_timer_pool.sv
// top level: ms counter, slot pool in ram, read-modify-write for slot checks
// tick, open, read, clear and checks that need no slot access register their
// result directly; a check of a slot in use first reads the slot ram, then
// compares and writes back. one item in flight at a time: a new item is taken
// only while idle and while a valid result is not held by the output stall.
// synchronous active-low reset clears the counter, use bits and handshake;
// the read stamp resets to all ones. slot ram contents need no reset.
`timescale 1ns / 1ps

module periodic_slot_timer_pool (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [15:0] i_period_ms,
    input  logic [7:0]  i_slot_handle,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_handle_out,
    output logic        o_elapsed,
    output logic [31:0] o_time_now,
    output logic        o_first_call
);

    localparam int IW = pstp_pkg::IDX_W;

    pstp_pkg::t_state r_state, n_state;

    logic [31:0]                 r_counter;
    logic [31:0]                 r_stamp;
    logic [pstp_pkg::POOL_SIZE-1:0] r_in_use;
    logic [IW-1:0]               r_chk_idx;

    logic        r_out_valid;
    logic [7:0]  r_handle_out;
    logic        r_elapsed;
    logic [31:0] r_time_now;
    logic        r_first_call;

    logic          w_accept;
    logic          w_free_found;
    logic [IW-1:0] w_free_idx;
    logic          w_handle_ok;
    logic [7:0]    w_handle_m1;
    logic [IW-1:0] w_chk_idx;
    logic          w_to_check;
    logic          w_load_now;
    logic          w_chk_pass;

    logic          w_we;
    logic [IW-1:0] w_waddr;
    pstp_pkg::t_slot w_wdata, w_rdata;

    assign o_in_stall = (r_state != pstp_pkg::ST_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    // lowest free slot
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = pstp_pkg::POOL_SIZE - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = IW'(i);
            end
        end
    end

    assign w_handle_m1 = i_slot_handle - 8'd1;
    assign w_chk_idx   = w_handle_m1[IW-1:0];
    assign w_handle_ok = (i_slot_handle != 8'd0)
                      && (i_slot_handle <= 8'(pstp_pkg::POOL_SIZE));

    assign w_chk_pass = (r_counter - w_rdata.last_time) >= {16'd0, w_rdata.period};

    always_comb begin
        n_state    = r_state;
        w_to_check = 1'b0;
        w_load_now = 1'b0;
        unique case (r_state)
            pstp_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_mode == pstp_pkg::MODE_CHECK && w_handle_ok
                        && r_in_use[w_chk_idx]) begin
                        w_to_check = 1'b1;
                        n_state    = pstp_pkg::ST_CHECK;
                    end else begin
                        w_load_now = 1'b1;
                    end
                end
            end
            pstp_pkg::ST_CHECK: begin
                n_state = pstp_pkg::ST_IDLE;
            end
            default: n_state = pstp_pkg::ST_IDLE;
        endcase
    end

    // slot ram writes: open fills a new slot, a passing check restamps
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_free_idx;
        w_wdata.period    = i_period_ms;
        w_wdata.last_time = r_counter;
        if (r_state == pstp_pkg::ST_CHECK) begin
            w_we    = w_chk_pass;
            w_waddr = r_chk_idx;
            w_wdata.period = w_rdata.period;
        end else if (w_load_now && i_mode == pstp_pkg::MODE_OPEN) begin
            w_we = w_free_found;
        end
    end

    pstp_ram #(
        .WIDTH ($bits(pstp_pkg::t_slot)),
        .DEPTH (pstp_pkg::POOL_SIZE)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_chk_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pstp_pkg::ST_IDLE;
            r_counter   <= '0;
            r_stamp     <= pstp_pkg::STAMP_SENTINEL;
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_now || r_state == pstp_pkg::ST_CHECK) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_load_now) begin
                unique case (i_mode)
                    pstp_pkg::MODE_TICK:  r_counter <= r_counter + 32'd1;
                    pstp_pkg::MODE_OPEN: begin
                        if (w_free_found) begin
                            r_in_use[w_free_idx] <= 1'b1;
                        end
                    end
                    pstp_pkg::MODE_READ:  r_stamp  <= r_counter;
                    pstp_pkg::MODE_CLEAR: r_in_use <= '0;
                    default: ;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_to_check) begin
            r_chk_idx <= w_chk_idx;
        end
        if (w_load_now) begin
            r_handle_out <= (i_mode == pstp_pkg::MODE_OPEN && w_free_found)
                          ? 8'({1'b0, w_free_idx} + (IW + 1)'(1)) : 8'd0;
            r_elapsed    <= 1'b0;
            r_time_now   <= (i_mode == pstp_pkg::MODE_TICK) ? r_counter + 32'd1 : r_counter;
            r_first_call <= (i_mode == pstp_pkg::MODE_READ)
                          && (r_stamp == pstp_pkg::STAMP_SENTINEL);
        end else if (r_state == pstp_pkg::ST_CHECK) begin
            r_handle_out <= 8'd0;
            r_elapsed    <= w_chk_pass;
            r_time_now   <= r_counter;
            r_first_call <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_handle_out = r_handle_out;
    assign o_elapsed    = r_elapsed;
    assign o_time_now   = r_time_now;
    assign o_first_call = r_first_call;

endmodule

FILE: bench/slot_timer_checker.sv
// checker for the slot timer pool: predicts every result beat and compares it field by field
`timescale 1ns / 1ps

module slot_timer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [15:0] i_period_ms,
    input  logic [7:0]  i_slot_handle,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_handle_out,
    input  logic        i_elapsed,
    input  logic [31:0] i_time_now,
    input  logic        i_first_call,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0]  handle;
        logic        elapsed;
        logic [31:0] now;
        logic        first;
    } t_timer_result;

    // own copy of the timer state
    logic [31:0] ms_now;
    logic [15:0] slot_period [pstp_pkg::POOL_SIZE];
    logic        slot_busy   [pstp_pkg::POOL_SIZE];
    logic [31:0] slot_stamp  [pstp_pkg::POOL_SIZE];
    logic [31:0] read_stamp;

    t_timer_result expected_results[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    task automatic free_all_slots();
        for (int k = 0; k < pstp_pkg::POOL_SIZE; k++) begin
            slot_period[k] = '0;
            slot_busy[k]   = 1'b0;
            slot_stamp[k]  = '0;
        end
    endtask

    task automatic step_timer_pool(input logic [2:0] mode, input logic [15:0] period,
                                   input logic [7:0] handle, output t_timer_result res);
        int          idx;
        logic [31:0] age;
        res = '0;
        case (mode)
            pstp_pkg::MODE_TICK: begin
                ms_now = ms_now + 32'd1;
            end
            pstp_pkg::MODE_OPEN: begin
                for (idx = 0; idx < pstp_pkg::POOL_SIZE; idx++) begin
                    if (!slot_busy[idx] && res.handle == 8'd0) begin
                        slot_busy[idx]   = 1'b1;
                        slot_period[idx] = period;
                        slot_stamp[idx]  = ms_now;
                        res.handle       = 8'(idx + 1);
                    end
                end
            end
            pstp_pkg::MODE_CHECK: begin
                if (handle != 8'd0 && handle <= 8'(pstp_pkg::POOL_SIZE)) begin
                    idx = int'(handle) - 1;
                    // unsigned wrap on the age
                    age = ms_now - slot_stamp[idx];
                    if (slot_busy[idx] && age >= {16'd0, slot_period[idx]}) begin
                        slot_stamp[idx] = ms_now;
                        res.elapsed     = 1'b1;
                    end
                end
            end
            pstp_pkg::MODE_READ: begin
                res.first  = (read_stamp == pstp_pkg::STAMP_SENTINEL);
                read_stamp = ms_now;
            end
            pstp_pkg::MODE_CLEAR: begin
                free_all_slots();
            end
            default: begin
            end
        endcase
        res.now = ms_now;
    endtask

    always @(posedge i_clk) begin
        t_timer_result got;
        t_timer_result want;
        t_timer_result pred;
        if (!i_rst_n) begin
            ms_now     = '0;
            read_stamp = pstp_pkg::STAMP_SENTINEL;
            free_all_slots();
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.handle  = i_handle_out;
                got.elapsed = i_elapsed;
                got.now     = i_time_now;
                got.first   = i_first_call;
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected", i_time_now, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.handle != want.handle)
                        report_mismatch("handle_out", 32'(got.handle), 32'(want.handle));
                    if (got.elapsed != want.elapsed)
                        report_mismatch("elapsed", 32'(got.elapsed), 32'(want.elapsed));
                    if (got.now != want.now)
                        report_mismatch("time_now", got.now, want.now);
                    if (got.first != want.first)
                        report_mismatch("first_call", 32'(got.first), 32'(want.first));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                step_timer_pool(i_mode, i_period_ms, i_slot_handle, pred);
                expected_results.push_back(pred);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: bench/periodic_slot_timer_pool_tb.sv
// testbench top for the slot timer pool: reset, directed and random beats, verdict
`timescale 1ns / 1ps

module periodic_slot_timer_pool_tb;

    localparam int          CYCLE_LIMIT      = 200000;
    localparam int          HOLD_LEN         = 300;
    localparam int          RANDOM_PER_PHASE = 200;
    localparam int          DRAIN_CYCLES     = 4;
    localparam logic [2:0]  MODE_SPARE_FIRST = pstp_pkg::MODE_CLEAR + 3'd1;
    localparam logic [2:0]  MODE_SPARE_LAST  = 3'd7;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [2:0]  i_mode        = '0;
    logic [15:0] i_period_ms   = '0;
    logic [7:0]  i_slot_handle = '0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_handle_out;
    logic        o_elapsed;
    logic [31:0] o_time_now;
    logic        o_first_call;

    int          fail_count;
    int          pending;
    int unsigned send_idle_pct = 26;
    int unsigned recv_idle_pct = 60;
    int unsigned cycle_count   = 0;
    int unsigned hold_left     = 0;
    logic        hold_toggle   = 1'b0;
    logic        hold_seen     = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    periodic_slot_timer_pool dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_period_ms   (i_period_ms),
        .i_slot_handle (i_slot_handle),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_handle_out  (o_handle_out),
        .o_elapsed     (o_elapsed),
        .o_time_now    (o_time_now),
        .o_first_call  (o_first_call)
    );

    slot_timer_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_period_ms   (i_period_ms),
        .i_slot_handle (i_slot_handle),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_handle_out  (o_handle_out),
        .i_elapsed     (o_elapsed),
        .i_time_now    (o_time_now),
        .i_first_call  (o_first_call),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // result side: random stall, or a long hold-off when the toggle flips
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen   <= hold_toggle;
            hold_left   <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_item(input logic [2:0] mode, input logic [15:0] period,
                             input logic [7:0] handle);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_period_ms   <= period;
        i_slot_handle <= handle;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_random_item();
        int unsigned roll;
        logic [2:0]  mode;
        logic [15:0] period;
        logic [7:0]  handle;
        roll   = $urandom_range(99);
        period = 16'($urandom);
        handle = 8'($urandom);
        if (roll < 35) begin
            mode = pstp_pkg::MODE_TICK;
        end else if (roll < 50) begin
            mode = pstp_pkg::MODE_OPEN;
            // mostly short periods so that checks fire
            if ($urandom_range(99) < 70)
                period = 16'($urandom_range(15));
        end else if (roll < 80) begin
            mode = pstp_pkg::MODE_CHECK;
            if ($urandom_range(99) < 80)
                handle = 8'($urandom_range(pstp_pkg::POOL_SIZE, 1));
        end else if (roll < 88) begin
            mode = pstp_pkg::MODE_READ;
        end else if (roll < 92) begin
            mode = pstp_pkg::MODE_CLEAR;
        end else begin
            mode = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
        end
        send_item(mode, period, handle);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first call flag, then cleared by the read stamp
        send_item(pstp_pkg::MODE_READ, 16'hFFFF, 8'hFF);
        send_item(pstp_pkg::MODE_READ, 16'h0000, 8'h00);
        // zero period, largest period, then fill the pool
        send_item(pstp_pkg::MODE_OPEN, 16'h0000, 8'h00);
        send_item(pstp_pkg::MODE_OPEN, 16'hFFFF, 8'hFF);
        for (int k = 2; k < pstp_pkg::POOL_SIZE; k++)
            send_item(pstp_pkg::MODE_OPEN, 16'(k), 8'h00);
        send_item(pstp_pkg::MODE_OPEN, 16'd5, 8'h00);
        send_item(pstp_pkg::MODE_CHECK, 16'hFFFF, 8'd1);
        send_item(pstp_pkg::MODE_CHECK, 16'h0000, 8'd2);
        // invalid handles
        send_item(pstp_pkg::MODE_CHECK, 16'h0000, 8'd0);
        send_item(pstp_pkg::MODE_CHECK, 16'h0000, 8'(pstp_pkg::POOL_SIZE + 1));
        send_item(pstp_pkg::MODE_CHECK, 16'h0000, 8'hFF);
        send_item(pstp_pkg::MODE_TICK, 16'hFFFF, 8'hFF);
        send_item(pstp_pkg::MODE_TICK, 16'h0000, 8'h00);
        send_item(pstp_pkg::MODE_CHECK, 16'h0000, 8'd3);
        send_item(MODE_SPARE_FIRST, 16'hFFFF, 8'hFF);
        send_item(MODE_SPARE_LAST, 16'hFFFF, 8'hFF);
        send_item(pstp_pkg::MODE_CLEAR, 16'h0000, 8'h00);
        // slot freed by the clear
        send_item(pstp_pkg::MODE_CHECK, 16'h0000, 8'd1);
        send_item(pstp_pkg::MODE_OPEN, 16'd1, 8'h00);
        send_item(pstp_pkg::MODE_TICK, 16'h0000, 8'h00);
        send_item(pstp_pkg::MODE_CHECK, 16'h0000, 8'd1);
        send_item(pstp_pkg::MODE_READ, 16'h0000, 8'h00);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 26;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 26;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (phase == 0 && n == RANDOM_PER_PHASE / 2)
                    hold_toggle = ~hold_toggle;
                if (phase == 1 && n == RANDOM_PER_PHASE / 2)
                    wait_results_drained();
                send_random_item();
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
